>>> hdl/mrc_pkg.sv
// shared types and constants for the motion range classifier
package mrc_pkg;

  localparam int unsigned AngleW = 16;
  localparam int unsigned LimitW = 16;
  localparam int unsigned CountOutW = 9;
  localparam int unsigned RadW = 34;
  localparam int unsigned RootW = 17;

  localparam logic [1:0] REG_SMALL_LIMIT = 2'd0;
  localparam logic [1:0] REG_LARGE_LIMIT = 2'd1;
  localparam logic [1:0] REG_RETURN_TOL  = 2'd2;

  localparam logic [LimitW-1:0] SMALL_LIMIT_RST = 16'd1920;
  localparam logic [LimitW-1:0] LARGE_LIMIT_RST = 16'd3840;
  localparam logic [LimitW-1:0] RETURN_TOL_RST  = 16'd640;

  localparam logic [1:0] SEL_RANGE = 2'd0;
  localparam logic [1:0] SEL_START = 2'd1;
  localparam logic [1:0] SEL_END   = 2'd2;

  localparam logic [1:0] CLASS_SMALL  = 2'd0;
  localparam logic [1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [1:0] CLASS_LARGE  = 2'd2;

  typedef struct packed {
    logic       sample;
    logic       sq_a;
    logic       sq_b;
    logic       root_start;
    logic       root_store;
    logic [1:0] sel;
    logic       drift_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic close_hit;
    logic root_done;
    logic out_free;
  } status_t;

endpackage

>>> hdl/mrc_in_if.sv
// sample channel: roll and pitch beat
interface mrc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;

  modport source (output valid, output roll_angle, output pitch_angle, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

>>> hdl/mrc_out_if.sv
// result channel: range, class, drift, returned flag and count
interface mrc_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] range_magnitude;
  logic        [1:0]  motion_class;
  logic signed [15:0] tilt_drift;
  logic               returned;
  logic        [8:0]  sample_count;

  modport source (
    output valid, output range_magnitude, output motion_class, output tilt_drift,
    output returned, output sample_count, input ready
  );
  modport sink (
    input valid, input range_magnitude, input motion_class, input tilt_drift,
    input returned, input sample_count, output ready
  );
endinterface

>>> hdl/motion_range_classifier.sv
// top level: roll/pitch run tracker with range, class and drift report
// a sample that does not close the run leaves the input ready; the next beat is accepted right after it
// a closing beat reaches its result after three passes through the
// shared squarer and the bit-serial square root (17 steps each), then drift and class
// a finished result waits in the output register while new samples are taken
// reset clears the run, the output valid and loads the default limits
module motion_range_classifier #(
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mrc_in_if.sink          in_if,
  mrc_out_if.source       out_if,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [15:0]     cfg_data_i
);
  import mrc_pkg::*;

  cmd_t    cmd;
  status_t status;

  mrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mrc_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .roll_angle_i      (in_if.roll_angle),
    .pitch_angle_i     (in_if.pitch_angle),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_if.valid),
    .out_ready_i       (out_if.ready),
    .range_magnitude_o (out_if.range_magnitude),
    .motion_class_o    (out_if.motion_class),
    .tilt_drift_o      (out_if.tilt_drift),
    .returned_o        (out_if.returned),
    .sample_count_o    (out_if.sample_count)
  );
endmodule

>>> hdl/mrc_sqrt.sv
// bit-serial integer square root, two radicand bits per cycle
module mrc_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mrc_pkg::RadW-1:0]  radicand_i,
  output logic                      done_o,
  output logic [mrc_pkg::RootW-1:0] root_o
);
  import mrc_pkg::*;

  localparam int unsigned RemW = RootW + 3;
  localparam int unsigned CntW = $clog2(RootW);
  localparam logic [CntW-1:0] LastStep = CntW'(RootW - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RadW-1:0] rad_q, rad_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = RemW'({root_q, 2'b01});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

>>> hdl/mrc_ctrl.sv
// sequencer: sample intake, three root passes, result handoff
module mrc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mrc_pkg::status_t status_i,
  output mrc_pkg::cmd_t    cmd_o
);
  import mrc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQA   = 3'd1;
  localparam logic [2:0] S_SQB   = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DRIFT = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.sample = accept;
        if (accept && status_i.close_hit) begin
          sel_d   = SEL_RANGE;
          state_d = S_SQA;
        end
      end
      S_SQA: begin
        cmd_o.sq_a = 1'b1;
        state_d    = S_SQB;
      end
      S_SQB: begin
        cmd_o.sq_b = 1'b1;
        state_d    = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_start = 1'b1;
        state_d          = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.root_done) begin
          cmd_o.root_store = 1'b1;
          if (sel_q == SEL_END) begin
            state_d = S_DRIFT;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = S_SQA;
          end
        end
      end
      S_DRIFT: begin
        cmd_o.drift_en = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= SEL_RANGE;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end
endmodule

>>> hdl/mrc_dp.sv
// datapath: run tracking, squaring, roots, classification and result register
module mrc_dp #(
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mrc_pkg::cmd_t                     cmd_i,
  output mrc_pkg::status_t                  status_o,
  input  logic signed [mrc_pkg::AngleW-1:0] roll_angle_i,
  input  logic signed [mrc_pkg::AngleW-1:0] pitch_angle_i,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [mrc_pkg::LimitW-1:0]        cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [15:0]                       range_magnitude_o,
  output logic [1:0]                        motion_class_o,
  output logic signed [15:0]                tilt_drift_o,
  output logic                              returned_o,
  output logic [mrc_pkg::CountOutW-1:0]     sample_count_o
);
  import mrc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CntW-1:0] CountLast = CntW'(MAX_SAMPLES - 1);
  localparam int unsigned DriftW = RootW + 1;

  // configuration
  logic [LimitW-1:0] small_lim_q, large_lim_q, ret_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_lim_q <= SMALL_LIMIT_RST;
      large_lim_q <= LARGE_LIMIT_RST;
      ret_tol_q   <= RETURN_TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SMALL_LIMIT: small_lim_q <= cfg_data_i;
        REG_LARGE_LIMIT: large_lim_q <= cfg_data_i;
        REG_RETURN_TOL:  ret_tol_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // run state
  logic signed [AngleW-1:0] roll_lo_q, roll_hi_q, pitch_lo_q, pitch_hi_q;
  logic signed [AngleW-1:0] first_roll_q, first_pitch_q, last_roll_q, last_pitch_q;
  logic [CntW-1:0]          count_q;
  logic                     take;

  assign take = cmd_i.sample && (roll_angle_i != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_lo_q     <= '0;
      roll_hi_q     <= '0;
      pitch_lo_q    <= '0;
      pitch_hi_q    <= '0;
      first_roll_q  <= '0;
      first_pitch_q <= '0;
      last_roll_q   <= '0;
      last_pitch_q  <= '0;
      count_q       <= '0;
    end else if (cmd_i.out_load) begin
      roll_lo_q     <= '0;
      roll_hi_q     <= '0;
      pitch_lo_q    <= '0;
      pitch_hi_q    <= '0;
      first_roll_q  <= '0;
      first_pitch_q <= '0;
      last_roll_q   <= '0;
      last_pitch_q  <= '0;
      count_q       <= '0;
    end else if (take) begin
      if (count_q == '0) begin
        roll_lo_q     <= roll_angle_i;
        roll_hi_q     <= roll_angle_i;
        pitch_lo_q    <= pitch_angle_i;
        pitch_hi_q    <= pitch_angle_i;
        first_roll_q  <= roll_angle_i;
        first_pitch_q <= pitch_angle_i;
      end else begin
        if (roll_angle_i < roll_lo_q) roll_lo_q <= roll_angle_i;
        if (roll_angle_i > roll_hi_q) roll_hi_q <= roll_angle_i;
        if (pitch_angle_i < pitch_lo_q) pitch_lo_q <= pitch_angle_i;
        if (pitch_angle_i > pitch_hi_q) pitch_hi_q <= pitch_angle_i;
      end
      last_roll_q  <= roll_angle_i;
      last_pitch_q <= pitch_angle_i;
      count_q      <= count_q + CntW'(1);
    end
  end

  // operand select and shared squarer
  logic signed [AngleW:0]  op_a, op_b, op;
  logic signed [RadW-1:0]  sq_full;
  logic [RadW-1:0]         prod_q, acc_q;

  always_comb begin
    case (cmd_i.sel)
      SEL_START: begin
        op_a = {first_roll_q[AngleW-1], first_roll_q};
        op_b = {first_pitch_q[AngleW-1], first_pitch_q};
      end
      SEL_END: begin
        op_a = {last_roll_q[AngleW-1], last_roll_q};
        op_b = {last_pitch_q[AngleW-1], last_pitch_q};
      end
      default: begin
        op_a = {roll_hi_q[AngleW-1], roll_hi_q} - {roll_lo_q[AngleW-1], roll_lo_q};
        op_b = {pitch_hi_q[AngleW-1], pitch_hi_q} - {pitch_lo_q[AngleW-1], pitch_lo_q};
      end
    endcase
  end

  assign op      = cmd_i.sq_b ? op_b : op_a;
  assign sq_full = op * op;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_a || cmd_i.sq_b) begin
      prod_q <= sq_full;
    end
    if (cmd_i.sq_b) begin
      acc_q <= prod_q;
    end
  end

  // square root and root results
  logic                    root_done;
  logic [RootW-1:0]        root;
  logic [RootW-1:0]        range_q, start_q, end_q;
  logic signed [DriftW-1:0] drift_q;

  mrc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.root_start),
    .radicand_i (acc_q + prod_q),
    .done_o     (root_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_store) begin
      case (cmd_i.sel)
        SEL_START: start_q <= root;
        SEL_END:   end_q   <= root;
        default:   range_q <= root;
      endcase
    end
    if (cmd_i.drift_en) begin
      drift_q <= $signed({1'b0, end_q}) - $signed({1'b0, start_q});
    end
  end

  // classification and saturation
  logic [15:0]             mag;
  logic [1:0]              cls;
  logic [DriftW-1:0]       abs_drift;
  logic signed [15:0]      drift_sat;
  logic [31:0]             cnt_ext;
  logic [CountOutW-1:0]    cnt_sat;

  assign mag = range_q[RootW-1] ? 16'hFFFF : range_q[15:0];

  always_comb begin
    if (mag < small_lim_q) begin
      cls = CLASS_SMALL;
    end else if (mag >= large_lim_q) begin
      cls = CLASS_LARGE;
    end else begin
      cls = CLASS_MEDIUM;
    end
  end

  assign abs_drift = drift_q[DriftW-1] ? DriftW'(-drift_q) : DriftW'(drift_q);

  always_comb begin
    if (drift_q > $signed(DriftW'(32767))) begin
      drift_sat = 16'sh7FFF;
    end else if (drift_q < -$signed(DriftW'(32768))) begin
      drift_sat = -16'sh8000;
    end else begin
      drift_sat = drift_q[15:0];
    end
  end

  assign cnt_ext = 32'(count_q);
  assign cnt_sat = (cnt_ext > 32'd511) ? 9'd511 : cnt_ext[CountOutW-1:0];

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      range_magnitude_o <= mag;
      motion_class_o    <= cls;
      tilt_drift_o      <= drift_sat;
      returned_o        <= (abs_drift < DriftW'(ret_tol_q));
      sample_count_o    <= cnt_sat;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.close_hit = (roll_angle_i == '0) || (count_q == CountLast);
  assign status_o.root_done = root_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
endmodule

>>> hdl/mrc_checker.sv
// port-level checks for the motion range classifier, bound to the top level
module mrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [15:0] roll_angle_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] range_magnitude_i,
  input logic [1:0]  motion_class_i
);

  // a held result beat stays valid and keeps its range magnitude
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(range_magnitude_i))
    else $error("result beat dropped or changed while stalled");

  // a zero roll closes the run and the block goes busy
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (roll_angle_i == 16'd0) |=> !in_ready_i)
    else $error("input still ready after a closing beat");

  // a new result only comes out of the busy phase
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a closing computation");

  // class code three is never produced
  a_class_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (motion_class_i != 2'd3))
    else $error("invalid motion class");

endmodule

bind motion_range_classifier mrc_checker u_mrc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_if.valid),
  .in_ready_i        (in_if.ready),
  .roll_angle_i      (in_if.roll_angle),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .range_magnitude_i (out_if.range_magnitude),
  .motion_class_i    (out_if.motion_class)
);
